### rtl/arp_rr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ARP responder/resolver package
// Shared types and constants for the front end, command queue and packet
// serializer of the ARP responder/resolver core.
// ----------------------------------------------------------------------------
package arp_rr_pkg;

  localparam logic [4:0] PKT_LEN   = 5'd28;
  localparam logic [4:0] PKT_LAST  = 5'd27;
  localparam logic [4:0] HDR_END   = 5'd8;
  localparam logic [4:0] SMAC_END  = 5'd14;
  localparam logic [4:0] SIP_END   = 5'd18;
  localparam logic [4:0] TIP_START = 5'd24;

  localparam logic [7:0]  HW_TYPE_ETH    = 8'h01;
  localparam logic [15:0] PROTO_IPV4     = 16'h0800;
  localparam logic [7:0]  HW_ADDR_LEN    = 8'h06;
  localparam logic [7:0]  PROTO_ADDR_LEN = 8'h04;
  localparam logic [7:0]  ARP_OP_REQUEST = 8'h01;
  localparam logic [7:0]  ARP_OP_REPLY   = 8'h02;

  localparam logic RK_TX     = 1'b0;
  localparam logic RK_ANSWER = 1'b1;

  // The queue depth must stay a power of two so the pointers wrap freely.
  localparam int QPTR_W = 2;
  localparam int QUEUE_DEPTH = 1 << QPTR_W;
  localparam logic [QPTR_W:0] QCNT_FULL = (QPTR_W + 1)'(QUEUE_DEPTH);

  localparam logic [1:0] REG_OWN_MAC     = 2'd0;
  localparam logic [1:0] REG_OWN_IP      = 2'd1;
  localparam logic [1:0] REG_SUBNET_MASK = 2'd2;
  localparam logic [1:0] REG_GATEWAY_IP  = 2'd3;

  typedef enum logic [1:0] {
    OP_RX_BYTE = 2'd0,
    OP_RESOLVE = 2'd1,
    OP_QUERY   = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    CMD_REPLY   = 2'd0,
    CMD_REQUEST = 2'd1,
    CMD_ANSWER  = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [47:0] mac;
    logic [31:0] ip;
    logic        hit;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } push_t;

  typedef struct packed {
    logic [47:0] own_mac;
    logic [31:0] own_ip;
    logic [31:0] subnet_mask;
    logic [31:0] gateway_ip;
  } cfg_t;

endpackage

### rtl/arp_responder_resolver_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ARP responder/resolver core
// Answers ARP requests for our address, learns peers from ARP responses,
// sends broadcast resolve requests and answers resolve queries.
// ----------------------------------------------------------------------------
// Usage:
// The input channel takes one word per cycle: a received ARP payload byte,
// a resolve request or a resolve query. A word is accepted when in_valid is
// high and in_stall is low. in_stall rises only while the four-entry command
// queue is full.
// The result channel gives transmit payload bytes (28 per packet, tx_last on
// the final one) and query answers, one word per cycle while out_stall is
// low. A stalled word holds; the front end keeps accepting words until the
// queue fills.
// Ordering: the first result word of an input word is registered in the command
// queue and then in the output register, and a stall can hold it in between. A reply or
// resolve request occupies the serializer for its 28 payload bytes, a query answer
// for a single word; sustained input rate is one word per cycle as long as the
// emitted traffic keeps up.
// Configuration is written through cfg_we/cfg_index/cfg_wdata while the
// block is idle. Reset clears configuration, the receive byte count, the
// learned peer and the queue; the block is usable the cycle after reset.
// ----------------------------------------------------------------------------
module arp_responder_resolver_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [47:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_opcode,
  input  logic [7:0]  in_rx_byte,
  input  logic        in_rx_last,
  input  logic [31:0] in_ip_addr,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_result_kind,
  output logic [7:0]  out_tx_byte,
  output logic        out_tx_last,
  output logic        out_resolved,
  output logic [47:0] out_resolved_mac
);

  arp_rr_pkg::cfg_t  cfg_r, cfg_nxt;
  arp_rr_pkg::push_t push;
  arp_rr_pkg::cmd_t  head;
  logic              q_full;
  logic              head_valid;
  logic              pop;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        arp_rr_pkg::REG_OWN_MAC:     cfg_nxt.own_mac     = cfg_wdata;
        arp_rr_pkg::REG_OWN_IP:      cfg_nxt.own_ip      = cfg_wdata[31:0];
        arp_rr_pkg::REG_SUBNET_MASK: cfg_nxt.subnet_mask = cfg_wdata[31:0];
        arp_rr_pkg::REG_GATEWAY_IP:  cfg_nxt.gateway_ip  = cfg_wdata[31:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  arp_rr_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_opcode  (in_opcode),
    .in_rx_byte (in_rx_byte),
    .in_rx_last (in_rx_last),
    .in_ip_addr (in_ip_addr),
    .cfg        (cfg_r),
    .q_full     (q_full),
    .push       (push)
  );

  arp_rr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .full       (q_full),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  arp_rr_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .head_valid       (head_valid),
    .head             (head),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_kind  (out_result_kind),
    .out_tx_byte      (out_tx_byte),
    .out_tx_last      (out_tx_last),
    .out_resolved     (out_resolved),
    .out_resolved_mac (out_resolved_mac)
  );

endmodule

### rtl/arp_rr_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ARP responder/resolver front end
// Accepts input words, captures received ARP fields, validates packets,
// keeps the resolved peer and turns resolve requests, queries and valid ARP requests into queue commands.
// ----------------------------------------------------------------------------
module arp_rr_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          in_opcode,
  input  logic [7:0]          in_rx_byte,
  input  logic                in_rx_last,
  input  logic [31:0]         in_ip_addr,
  input  arp_rr_pkg::cfg_t    cfg,
  input  logic                q_full,
  output arp_rr_pkg::push_t   push
);

  arp_rr_pkg::op_t op;
  logic            accept;
  logic [4:0]      rx_count_r, rx_count_nxt, cnt_inc;
  logic [63:0]     hdr_r, hdr_nxt;
  logic [47:0]     smac_r, smac_nxt;
  logic [31:0]     sip_r, sip_nxt;
  logic [31:0]     tip_r, tip_nxt;
  logic [47:0]     lr_mac_r, lr_mac_nxt;
  logic [31:0]     lr_ip_r, lr_ip_nxt;
  logic            pkt_ok;
  logic            hit;

  assign op       = arp_rr_pkg::op_t'(in_opcode);
  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign cnt_inc  = (rx_count_r < arp_rr_pkg::PKT_LEN) ? rx_count_r + 5'd1 : rx_count_r;
  assign hit      = (lr_ip_r == in_ip_addr) ||
                    ((cfg.gateway_ip != 32'd0) && (lr_ip_r == cfg.gateway_ip));

  always_comb begin
    hdr_nxt      = hdr_r;
    smac_nxt     = smac_r;
    sip_nxt      = sip_r;
    tip_nxt      = tip_r;
    rx_count_nxt = rx_count_r;
    lr_mac_nxt   = lr_mac_r;
    lr_ip_nxt    = lr_ip_r;
    pkt_ok       = 1'b0;
    push         = '0;
    if (accept) begin
      unique case (op)
        arp_rr_pkg::OP_RX_BYTE: begin
          if (rx_count_r < arp_rr_pkg::HDR_END) begin
            hdr_nxt = {hdr_r[55:0], in_rx_byte};
          end else if (rx_count_r < arp_rr_pkg::SMAC_END) begin
            smac_nxt = {smac_r[39:0], in_rx_byte};
          end else if (rx_count_r < arp_rr_pkg::SIP_END) begin
            sip_nxt = {sip_r[23:0], in_rx_byte};
          end else if (rx_count_r >= arp_rr_pkg::TIP_START &&
                       rx_count_r < arp_rr_pkg::PKT_LEN) begin
            tip_nxt = {tip_r[23:0], in_rx_byte};
          end
          rx_count_nxt = cnt_inc;
          pkt_ok = (hdr_nxt[55:48] == arp_rr_pkg::HW_TYPE_ETH) &&
                   (hdr_nxt[47:32] == arp_rr_pkg::PROTO_IPV4) &&
                   (hdr_nxt[31:24] == arp_rr_pkg::HW_ADDR_LEN) &&
                   (hdr_nxt[23:16] == arp_rr_pkg::PROTO_ADDR_LEN) &&
                   (tip_nxt == cfg.own_ip);
          if (in_rx_last) begin
            rx_count_nxt = '0;
            if (cnt_inc == arp_rr_pkg::PKT_LEN && pkt_ok) begin
              if (hdr_nxt[7:0] == arp_rr_pkg::ARP_OP_REQUEST) begin
                push.valid    = 1'b1;
                push.cmd.kind = arp_rr_pkg::CMD_REPLY;
                push.cmd.mac  = smac_nxt;
                push.cmd.ip   = sip_nxt;
              end else if (hdr_nxt[7:0] == arp_rr_pkg::ARP_OP_REPLY) begin
                lr_mac_nxt = smac_nxt;
                lr_ip_nxt  = sip_nxt;
              end
            end
          end
        end
        arp_rr_pkg::OP_RESOLVE: begin
          lr_ip_nxt     = '0;
          push.valid    = 1'b1;
          push.cmd.kind = arp_rr_pkg::CMD_REQUEST;
          push.cmd.mac  = '1;
          push.cmd.ip   = in_ip_addr;
        end
        arp_rr_pkg::OP_QUERY: begin
          push.valid    = 1'b1;
          push.cmd.kind = arp_rr_pkg::CMD_ANSWER;
          push.cmd.mac  = lr_mac_r;
          push.cmd.hit  = hit;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_count_r <= '0;
      lr_mac_r   <= '0;
      lr_ip_r    <= '0;
    end else begin
      rx_count_r <= rx_count_nxt;
      lr_mac_r   <= lr_mac_nxt;
      lr_ip_r    <= lr_ip_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hdr_r  <= hdr_nxt;
    smac_r <= smac_nxt;
    sip_r  <= sip_nxt;
    tip_r  <= tip_nxt;
  end

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    rx_count_r <= arp_rr_pkg::PKT_LEN)
    else $error("receive byte count beyond packet length");

  a_push_only_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    push.valid |-> (in_valid && !q_full))
    else $error("command pushed without an accepted word");

endmodule

### rtl/arp_rr_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ARP responder/resolver command queue
// Short first-in first-out queue of commands between the front end and the
// packet serializer.
// ----------------------------------------------------------------------------
module arp_rr_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  arp_rr_pkg::push_t  push,
  output logic               full,
  output logic               head_valid,
  output arp_rr_pkg::cmd_t   head,
  input  logic               pop
);

  arp_rr_pkg::cmd_t                mem_r [arp_rr_pkg::QUEUE_DEPTH];
  logic [arp_rr_pkg::QPTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [arp_rr_pkg::QPTR_W:0]     count_r, count_nxt;
  logic                            do_push, do_pop;

  assign full       = (count_r == arp_rr_pkg::QCNT_FULL);
  assign head_valid = (count_r != '0);
  assign head       = mem_r[rd_ptr_r];
  assign do_push    = push.valid && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push.cmd;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= arp_rr_pkg::QCNT_FULL)
    else $error("command queue count overflow");

endmodule

### rtl/arp_rr_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ARP responder/resolver packet serializer
// Takes commands from the queue and drives the result channel: 28 payload
// bytes for a request or reply, one word for a query answer.
// ----------------------------------------------------------------------------
module arp_rr_back (
  input  logic               clk,
  input  logic               rst_n,
  input  arp_rr_pkg::cfg_t   cfg,
  input  logic               head_valid,
  input  arp_rr_pkg::cmd_t   head,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_result_kind,
  output logic [7:0]         out_tx_byte,
  output logic               out_tx_last,
  output logic               out_resolved,
  output logic [47:0]        out_resolved_mac
);

  logic [4:0]  idx_r, idx_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        out_kind_r;
  logic [7:0]  out_byte_r;
  logic        out_last_r;
  logic        out_res_r;
  logic [47:0] out_mac_r;
  logic        load;
  logic        is_answer;
  logic        pkt_end;
  logic [31:0] tgt_ip;
  logic [7:0]  arp_op;
  logic [7:0]  pkt_bytes [arp_rr_pkg::PKT_LEN];

  assign is_answer = (head.kind == arp_rr_pkg::CMD_ANSWER);
  assign load      = head_valid && (!out_valid_r || !out_stall);
  assign pkt_end   = (idx_r == arp_rr_pkg::PKT_LAST);
  assign pop       = load && (is_answer || pkt_end);
  assign tgt_ip    = (((cfg.own_ip ^ head.ip) & cfg.subnet_mask) != 32'd0) ?
                     cfg.gateway_ip : head.ip;
  assign arp_op    = (head.kind == arp_rr_pkg::CMD_REPLY) ?
                     arp_rr_pkg::ARP_OP_REPLY : arp_rr_pkg::ARP_OP_REQUEST;

  always_comb begin
    pkt_bytes[0]  = 8'h00;
    pkt_bytes[1]  = arp_rr_pkg::HW_TYPE_ETH;
    pkt_bytes[2]  = arp_rr_pkg::PROTO_IPV4[15:8];
    pkt_bytes[3]  = arp_rr_pkg::PROTO_IPV4[7:0];
    pkt_bytes[4]  = arp_rr_pkg::HW_ADDR_LEN;
    pkt_bytes[5]  = arp_rr_pkg::PROTO_ADDR_LEN;
    pkt_bytes[6]  = 8'h00;
    pkt_bytes[7]  = arp_op;
    pkt_bytes[8]  = cfg.own_mac[47:40];
    pkt_bytes[9]  = cfg.own_mac[39:32];
    pkt_bytes[10] = cfg.own_mac[31:24];
    pkt_bytes[11] = cfg.own_mac[23:16];
    pkt_bytes[12] = cfg.own_mac[15:8];
    pkt_bytes[13] = cfg.own_mac[7:0];
    pkt_bytes[14] = cfg.own_ip[31:24];
    pkt_bytes[15] = cfg.own_ip[23:16];
    pkt_bytes[16] = cfg.own_ip[15:8];
    pkt_bytes[17] = cfg.own_ip[7:0];
    pkt_bytes[18] = head.mac[47:40];
    pkt_bytes[19] = head.mac[39:32];
    pkt_bytes[20] = head.mac[31:24];
    pkt_bytes[21] = head.mac[23:16];
    pkt_bytes[22] = head.mac[15:8];
    pkt_bytes[23] = head.mac[7:0];
    pkt_bytes[24] = tgt_ip[31:24];
    pkt_bytes[25] = tgt_ip[23:16];
    pkt_bytes[26] = tgt_ip[15:8];
    pkt_bytes[27] = tgt_ip[7:0];
  end

  always_comb begin
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
      if (!is_answer) begin
        idx_nxt = pkt_end ? 5'd0 : idx_r + 5'd1;
      end
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (is_answer) begin
        out_kind_r <= arp_rr_pkg::RK_ANSWER;
        out_byte_r <= 8'h00;
        out_last_r <= 1'b0;
        out_res_r  <= head.hit;
        out_mac_r  <= head.mac;
      end else begin
        out_kind_r <= arp_rr_pkg::RK_TX;
        out_byte_r <= pkt_bytes[idx_r];
        out_last_r <= pkt_end;
        out_res_r  <= 1'b0;
        out_mac_r  <= '0;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_kind  = out_kind_r;
  assign out_tx_byte      = out_byte_r;
  assign out_tx_last      = out_last_r;
  assign out_resolved     = out_res_r;
  assign out_resolved_mac = out_mac_r;

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= arp_rr_pkg::PKT_LAST)
    else $error("byte index beyond packet end");

  a_mid_packet_head: assert property (@(posedge clk) disable iff (!rst_n)
    (idx_r != 5'd0) |-> (head_valid && !is_answer))
    else $error("packet in progress without a packet command at the head");

  a_last_is_tx: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |-> (out_kind_r == arp_rr_pkg::RK_TX))
    else $error("last flag on a query answer");

endmodule
